[hdl/state_variable_filter_2x_unit_defines.svh]
// Assertion macros shared by the state-variable filter RTL.
`ifndef STATE_VARIABLE_FILTER_2X_UNIT_DEFINES_SVH
`define STATE_VARIABLE_FILTER_2X_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define SVF2X_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define SVF2X_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/svf2x_pkg.sv]
// Shared constants and types of the state-variable filter.
package svf2x_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int STATE_WIDTH_DEF  = 32;

	localparam int COEF_W    = 17;
	localparam int CTRL_W    = 16;
	localparam int GAIN_W    = 17;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [COEF_W-1:0] TRIM_SLOPE  = 17'd9830;
	localparam logic [COEF_W-1:0] TRIM_OFFSET = 17'd55706;
	localparam logic [COEF_W-1:0] TRIM_SCALE  = 17'd64881;
	localparam logic [COEF_W-1:0] UNITY_Q16   = 17'd65536;

	localparam logic [MODE_W-1:0] MODE_LOW   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HIGH  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BAND  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOTCH = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'b1;

	typedef struct packed {
		logic              start;
		logic [COEF_W-1:0] coef;
	} mul_ctrl_t;

endpackage

[hdl/svf2x_mul.sv]
// Bit-serial signed by unsigned multiplier, one coefficient bit per cycle.
module svf2x_mul #(
	parameter int A_WIDTH = svf2x_pkg::STATE_WIDTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  svf2x_pkg::mul_ctrl_t                       ctrl,
	input  logic signed [A_WIDTH-1:0]                  a,
	output logic                                       done,
	output logic signed [A_WIDTH+svf2x_pkg::COEF_W-1:0] prod
);

	localparam int P_W   = A_WIDTH + svf2x_pkg::COEF_W;
	localparam int CNT_W = $clog2(svf2x_pkg::COEF_W + 1);

	logic signed [A_WIDTH-1:0]        a_q;
	logic [svf2x_pkg::COEF_W-1:0]     b_q;
	logic signed [P_W-1:0]            acc_q;
	logic signed [P_W-1:0]            acc_next;
	logic [CNT_W-1:0]                 cnt_q;
	logic                             run_q;
	logic                             done_q;

	// MSB first: shift the partial sum left, then add the multiplicand if the bit is set.
	assign acc_next = (acc_q <<< 1) + (b_q[svf2x_pkg::COEF_W-1] ?
		{{svf2x_pkg::COEF_W{a_q[A_WIDTH-1]}}, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(svf2x_pkg::COEF_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			a_q   <= a;
			b_q   <= ctrl.coef;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_next;
			b_q   <= b_q << 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

[hdl/state_variable_filter_2x_unit.sv]
// Top level of the twice-oversampled state-variable filter.
//
//  channel  direction  handshake             payload
//  in       to block   in_valid / in_stall   sample_in, cutoff_coef, resonance_amt
//  out      from block out_valid / out_stall sample_out
//  cfg      to block   cfg_write             cfg_index, cfg_data
//
// Each item runs eleven multiplications in the one shared multiplier (a load, 17
// bit-serial steps, a done and a write-back each), then a hand-over and an idle state.
// Reset clears the filter state, the previous sample, mode (lowpass) and gain (1.0).
// A new item is taken only when the sequencer is idle; a finished result waits in the
// output register while the next item is already being worked on.
// A stall on the output holds the result and, once the next one is ready, the sequencer.
module state_variable_filter_2x_unit #(
	parameter int SAMPLE_WIDTH = svf2x_pkg::SAMPLE_WIDTH_DEF,
	parameter int STATE_WIDTH  = svf2x_pkg::STATE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
	input  logic [svf2x_pkg::CTRL_W-1:0]         cutoff_coef,
	input  logic [svf2x_pkg::CTRL_W-1:0]         resonance_amt,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
	input  logic                                 cfg_write,
	input  logic [svf2x_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [svf2x_pkg::GAIN_W-1:0]         cfg_data
);

`include "state_variable_filter_2x_unit_defines.svh"

	localparam int CW  = svf2x_pkg::COEF_W;
	localparam int P_W = STATE_WIDTH + CW;
	// Rounded products and the trim values live in EW bits; sums get one more.
	localparam int EW  = STATE_WIDTH + 2;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_WB   = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	// Operation sequence: three trim steps, then four steps for each pass.
	localparam logic [2:0] OP_TRIM = 3'd0;
	localparam logic [2:0] OP_RES  = 3'd1;
	localparam logic [2:0] OP_SCL  = 3'd2;
	localparam logic [2:0] OP_LOW  = 3'd3;
	localparam logic [2:0] OP_GAIN = 3'd4;
	localparam logic [2:0] OP_HIGH = 3'd5;
	localparam logic [2:0] OP_BAND = 3'd6;
	// The step counter rests here once the second pass has written back.
	localparam logic [2:0] OP_END  = 3'd7;

	localparam logic signed [EW:0] ST_MAX = {4'b0000, {(STATE_WIDTH-1){1'b1}}};
	localparam logic signed [EW:0] ST_MIN = ~ST_MAX;
	localparam logic signed [STATE_WIDTH-1:0] OUT_MAX =
		{{(STATE_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [STATE_WIDTH-1:0] OUT_MIN = ~OUT_MAX;
	localparam logic signed [P_W:0] HALF16 = (P_W+1)'(32768);
	localparam logic signed [P_W:0] HALF17 = (P_W+1)'(65536);

	function automatic logic signed [EW:0] ext_st(input logic signed [STATE_WIDTH-1:0] v);
		ext_st = {{3{v[STATE_WIDTH-1]}}, v};
	endfunction

	function automatic logic signed [EW:0] ext_e(input logic signed [EW-1:0] v);
		ext_e = {v[EW-1], v};
	endfunction

	function automatic logic signed [STATE_WIDTH-1:0] sat_st(input logic signed [EW:0] v);
		logic signed [EW:0] c;
		c = (v > ST_MAX) ? ST_MAX : ((v < ST_MIN) ? ST_MIN : v);
		sat_st = c[STATE_WIDTH-1:0];
	endfunction

	logic [2:0]                         state_q;
	logic [2:0]                         op_q;
	logic                               pass_q;
	logic [svf2x_pkg::MODE_W-1:0]       mode_q;
	logic [svf2x_pkg::GAIN_W-1:0]       gain_q;
	logic signed [SAMPLE_WIDTH-1:0]     sample_q;
	logic signed [SAMPLE_WIDTH-1:0]     prev_q;
	logic [svf2x_pkg::CTRL_W-1:0]       cutoff_q;
	logic [svf2x_pkg::CTRL_W-1:0]       res_q;
	logic signed [STATE_WIDTH-1:0]      low_q;
	logic signed [STATE_WIDTH-1:0]      high_q;
	logic signed [STATE_WIDTH-1:0]      band_q;
	logic signed [STATE_WIDTH-1:0]      notch_q;
	logic signed [EW-1:0]               tmp_q;
	logic [CW-1:0]                      damp_q;
	logic                               out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]     out_q;

	svf2x_pkg::mul_ctrl_t               mul_ctrl;
	logic signed [STATE_WIDTH-1:0]      mul_a;
	logic                               mul_done;
	logic signed [P_W-1:0]              mul_prod;

	logic signed [SAMPLE_WIDTH:0]       mid_sum;
	logic signed [SAMPLE_WIDTH-1:0]     pass_x;
	logic signed [P_W:0]                prod_ext;
	logic signed [P_W:0]                sum16;
	logic signed [P_W:0]                sum17;
	logic signed [P_W:0]                sh16;
	logic signed [P_W:0]                sh17;
	logic signed [EW-1:0]               rnd_val;
	logic signed [STATE_WIDTH-1:0]      sel_state;
	logic signed [STATE_WIDTH-1:0]      sel_sat;
	logic                               in_accept;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);

	// The first pass sees the floored midpoint of the previous and current sample.
	assign mid_sum = {prev_q[SAMPLE_WIDTH-1], prev_q} + {sample_q[SAMPLE_WIDTH-1], sample_q};
	assign pass_x  = pass_q ? sample_q : mid_sum[SAMPLE_WIDTH:1];

	// Operand selection for the shared multiplier, one operation at a time.
	always_comb begin
		mul_ctrl.start = (state_q == ST_LOAD);
		mul_ctrl.coef  = '0;
		mul_a          = '0;
		case (op_q)
			OP_TRIM: begin
				mul_a         = {{(STATE_WIDTH-svf2x_pkg::CTRL_W){1'b0}}, cutoff_q};
				mul_ctrl.coef = svf2x_pkg::TRIM_SLOPE;
			end
			OP_RES: begin
				mul_a         = {{(STATE_WIDTH-CW){1'b0}}, tmp_q[CW-1:0]};
				mul_ctrl.coef = {1'b0, res_q};
			end
			OP_SCL: begin
				mul_a         = {{(STATE_WIDTH-CW){1'b0}}, tmp_q[CW-1:0]};
				mul_ctrl.coef = svf2x_pkg::TRIM_SCALE;
			end
			OP_LOW: begin
				mul_a         = band_q;
				mul_ctrl.coef = {1'b0, cutoff_q};
			end
			OP_GAIN: begin
				mul_a         = {{(STATE_WIDTH-SAMPLE_WIDTH){pass_x[SAMPLE_WIDTH-1]}}, pass_x};
				mul_ctrl.coef = gain_q;
			end
			OP_HIGH: begin
				mul_a         = band_q;
				mul_ctrl.coef = damp_q;
			end
			OP_BAND: begin
				mul_a         = high_q;
				mul_ctrl.coef = {1'b0, cutoff_q};
			end
			default: begin
				mul_a         = '0;
				mul_ctrl.coef = '0;
			end
		endcase
	end

	svf2x_mul #(
		.A_WIDTH (STATE_WIDTH)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mul_ctrl),
		.a      (mul_a),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Round half up: add half an LSB, then shift arithmetically. The cutoff is read
	// as Q0.17, which makes the filter frequency half the coefficient.
	assign prod_ext = {mul_prod[P_W-1], mul_prod};
	assign sum16    = prod_ext + HALF16;
	assign sum17    = prod_ext + HALF17;
	assign sh16     = sum16 >>> 16;
	assign sh17     = sum17 >>> 17;
	assign rnd_val  = (op_q == OP_LOW || op_q == OP_BAND) ? sh17[EW-1:0] : sh16[EW-1:0];

	always_comb begin
		case (mode_q)
			svf2x_pkg::MODE_LOW:   sel_state = low_q;
			svf2x_pkg::MODE_HIGH:  sel_state = high_q;
			svf2x_pkg::MODE_BAND:  sel_state = band_q;
			svf2x_pkg::MODE_NOTCH: sel_state = notch_q;
			default:               sel_state = low_q;
		endcase
	end

	assign sel_sat = (sel_state > OUT_MAX) ? OUT_MAX :
		((sel_state < OUT_MIN) ? OUT_MIN : sel_state);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= svf2x_pkg::MODE_LOW;
			gain_q <= svf2x_pkg::UNITY_Q16;
		end else if (cfg_write) begin
			unique case (cfg_index)
				svf2x_pkg::REG_MODE: mode_q <= cfg_data[svf2x_pkg::MODE_W-1:0];
				svf2x_pkg::REG_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_TRIM;
			pass_q      <= 1'b0;
			prev_q      <= '0;
			low_q       <= '0;
			high_q      <= '0;
			band_q      <= '0;
			notch_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						op_q    <= OP_TRIM;
						pass_q  <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					state_q <= ST_LOAD;
					op_q    <= op_q + 1'b1;
					case (op_q)
						OP_LOW: begin
							low_q <= sat_st(ext_st(low_q) + ext_e(rnd_val));
						end
						OP_HIGH: begin
							high_q <= sat_st(ext_e(tmp_q) - ext_st(low_q) - ext_e(rnd_val));
						end
						OP_BAND: begin
							band_q  <= sat_st(ext_st(band_q) + ext_e(rnd_val));
							notch_q <= sat_st(ext_st(high_q) + ext_st(low_q));
							if (!pass_q) begin
								pass_q <= 1'b1;
								op_q   <= OP_LOW;
							end else begin
								prev_q  <= sample_q;
								state_q <= ST_DONE;
							end
						end
						default: ;
					endcase
				end
				ST_DONE: begin
					// Hand the result over once the previous one has been taken.
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_q <= sample_in;
			cutoff_q <= cutoff_coef;
			res_q    <= resonance_amt;
		end
		if (state_q == ST_WB) begin
			case (op_q)
				OP_TRIM: tmp_q  <= rnd_val + $signed({{(EW-CW){1'b0}}, svf2x_pkg::TRIM_OFFSET});
				OP_RES:  tmp_q  <= rnd_val;
				OP_SCL:  damp_q <= svf2x_pkg::UNITY_Q16 - rnd_val[CW-1:0];
				OP_GAIN: tmp_q  <= rnd_val;
				default: ;
			endcase
		end
		if (state_q == ST_DONE && !out_valid_q) begin
			out_q <= sel_sat[SAMPLE_WIDTH-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	`SVF2X_ASSERT_IMPL(a_done_in_mul, mul_done, state_q == ST_MUL,
		"multiplier finished outside the multiply state")
	`SVF2X_ASSERT_IMPL(a_out_from_done, $rose(out_valid), $past(state_q) == ST_DONE,
		"result appeared without the sequencer finishing")
	`SVF2X_ASSERT_IMPL(a_done_after_pass2, state_q == ST_DONE,
		pass_q && op_q == OP_END, "item finished before the second pass")
	`SVF2X_ASSERT_NEXT(a_accept_starts, in_accept,
		state_q == ST_LOAD && op_q == OP_TRIM && !pass_q, "accepted item did not start trim")

endmodule
